/* src/mclfsr_pkg.sv */
package mclfsr_pkg;

  // Register lengths and storage width
  localparam int unsigned LEN_A   = 4;
  localparam int unsigned LEN_B   = 7;
  localparam int unsigned LEN_C   = 9;
  localparam int unsigned MAX_LEN = 15;

  // Configuration port
  localparam int unsigned CFG_W     = 15;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_TAPS_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_B = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_C = 3'd5;

  localparam logic [CFG_W-1:0] TAPS_A_RST = 15'd12;
  localparam logic [CFG_W-1:0] TAPS_B_RST = 15'd72;
  localparam logic [CFG_W-1:0] TAPS_C_RST = 15'd272;
  localparam logic [CFG_W-1:0] SEED_RST   = 15'd1;

  typedef struct packed {
    logic [CFG_W-1:0] taps_a;
    logic [CFG_W-1:0] taps_b;
    logic [CFG_W-1:0] taps_c;
    logic [CFG_W-1:0] seed_a;
    logic [CFG_W-1:0] seed_b;
    logic [CFG_W-1:0] seed_c;
  } cfg_t;

  typedef struct packed {
    logic key_bit;
    logic bit_a;
    logic bit_b;
    logic bit_c;
  } res_t;

  // Ones in the low len bits
  function automatic logic [MAX_LEN-1:0] len_mask(input int unsigned len);
    logic [MAX_LEN-1:0] m;
    m = '0;
    for (int unsigned i = 0; i < MAX_LEN; i++) begin
      m[i] = (i < len);
    end
    return m;
  endfunction

  // One Fibonacci step: shift left, parity of tapped bits enters at bit 0
  function automatic logic [MAX_LEN-1:0] lfsr_next(input logic [MAX_LEN-1:0] cur,
                                                   input logic [CFG_W-1:0]   taps,
                                                   input int unsigned        len);
    logic [MAX_LEN-1:0] m;
    logic               fb;
    m  = len_mask(len);
    fb = ^(cur & taps & m);
    return ({cur[MAX_LEN-2:0], 1'b0} & m) | {{(MAX_LEN-1){1'b0}}, fb};
  endfunction

endpackage

/* src/majority_combined_lfsr_bit_generator_top.sv */
// A result appears on the output register in the cycle after its request is taken.
// Throughput: one request per cycle while the result side is not stalling; the three register
// updates and the majority vote are combinational, and the output register refills as it drains.
// Reset (rst, synchronous, active high): taps and seeds return to their defaults,
// shift registers clear, the output register empties; the first request loads seeds.
module majority_combined_lfsr_bit_generator_top (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [mclfsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mclfsr_pkg::CFG_W-1:0]       cfg_data,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               reload,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               key_bit,
  output logic                               bit_a,
  output logic                               bit_b,
  output logic                               bit_c
);

  mclfsr_pkg::cfg_t cfg;
  mclfsr_pkg::res_t res;
  logic             accept;

  // Hold the request side only while a result sits in the output register and
  // the downstream side is not taking it this cycle.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  mclfsr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Advance all three shift registers on every accepted request
  mclfsr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (accept),
    .reload (reload),
    .cfg    (cfg),
    .res    (res)
  );

  // Output register: valid flag under reset, payload loads with each request
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_bit <= res.key_bit;
      bit_a   <= res.bit_a;
      bit_b   <= res.bit_b;
      bit_c   <= res.bit_c;
    end
  end

endmodule

/* src/mclfsr_cfg.sv */
module mclfsr_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [mclfsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mclfsr_pkg::CFG_W-1:0]         cfg_data,
  output mclfsr_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.taps_a <= mclfsr_pkg::TAPS_A_RST;
      cfg.taps_b <= mclfsr_pkg::TAPS_B_RST;
      cfg.taps_c <= mclfsr_pkg::TAPS_C_RST;
      cfg.seed_a <= mclfsr_pkg::SEED_RST;
      cfg.seed_b <= mclfsr_pkg::SEED_RST;
      cfg.seed_c <= mclfsr_pkg::SEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mclfsr_pkg::CFG_TAPS_A: cfg.taps_a <= cfg_data;
        mclfsr_pkg::CFG_TAPS_B: cfg.taps_b <= cfg_data;
        mclfsr_pkg::CFG_TAPS_C: cfg.taps_c <= cfg_data;
        mclfsr_pkg::CFG_SEED_A: cfg.seed_a <= cfg_data;
        mclfsr_pkg::CFG_SEED_B: cfg.seed_b <= cfg_data;
        mclfsr_pkg::CFG_SEED_C: cfg.seed_c <= cfg_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

endmodule

/* src/mclfsr_core.sv */
module mclfsr_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              reload,
  input  mclfsr_pkg::cfg_t  cfg,
  output mclfsr_pkg::res_t  res
);

  logic [mclfsr_pkg::MAX_LEN-1:0] reg_a, reg_b, reg_c;
  logic [mclfsr_pkg::MAX_LEN-1:0] cur_a, cur_b, cur_c;
  logic [mclfsr_pkg::MAX_LEN-1:0] reg_a_next, reg_b_next, reg_c_next;
  logic                           started;
  logic                           load;

  // Load from seeds on the first step and on reload
  assign load  = !started || reload;
  assign cur_a = load ? (cfg.seed_a & mclfsr_pkg::len_mask(mclfsr_pkg::LEN_A)) : reg_a;
  assign cur_b = load ? (cfg.seed_b & mclfsr_pkg::len_mask(mclfsr_pkg::LEN_B)) : reg_b;
  assign cur_c = load ? (cfg.seed_c & mclfsr_pkg::len_mask(mclfsr_pkg::LEN_C)) : reg_c;

  assign reg_a_next = mclfsr_pkg::lfsr_next(cur_a, cfg.taps_a, mclfsr_pkg::LEN_A);
  assign reg_b_next = mclfsr_pkg::lfsr_next(cur_b, cfg.taps_b, mclfsr_pkg::LEN_B);
  assign reg_c_next = mclfsr_pkg::lfsr_next(cur_c, cfg.taps_c, mclfsr_pkg::LEN_C);

  always_comb begin
    res.bit_a   = cur_a[mclfsr_pkg::LEN_A-1];
    res.bit_b   = cur_b[mclfsr_pkg::LEN_B-1];
    res.bit_c   = cur_c[mclfsr_pkg::LEN_C-1];
    res.key_bit = (res.bit_a & res.bit_b) | (res.bit_b & res.bit_c) |
                  (res.bit_a & res.bit_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      reg_a   <= '0;
      reg_b   <= '0;
      reg_c   <= '0;
    end else if (step) begin
      started <= 1'b1;
      reg_a   <= reg_a_next;
      reg_b   <= reg_b_next;
      reg_c   <= reg_c_next;
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

  // Give up after this many cycles in which no request, result or register write moves.
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  // Cycles to linger once the last expected bit has arrived (output register depth is one).
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned RANDOM_PHASES  = 9;
  localparam int unsigned PHASE_REQUESTS = 205;

  // Indexes the block decodes to nothing; writes there must leave every register alone.
  localparam logic [mclfsr_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [mclfsr_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int unsigned SHIFT_LEN [3] = '{mclfsr_pkg::LEN_A, mclfsr_pkg::LEN_B,
                                            mclfsr_pkg::LEN_C};

  logic                             clk;
  logic                             rst;
  logic                             cfg_we;
  logic [mclfsr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mclfsr_pkg::CFG_W-1:0]     cfg_data;
  logic                             in_valid;
  logic                             in_stall;
  logic                             reload;
  logic                             out_valid;
  logic                             out_stall;
  logic                             key_bit;
  logic                             bit_a;
  logic                             bit_b;
  logic                             bit_c;

  majority_combined_lfsr_bit_generator_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .reload    (reload),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .key_bit   (key_bit),
    .bit_a     (bit_a),
    .bit_b     (bit_b),
    .bit_c     (bit_c)
  );

  // Shadow copy of the generator: shift registers, tap masks, seeds and the loaded flag.
  logic [mclfsr_pkg::MAX_LEN-1:0] shadow_lfsr [3];
  logic [mclfsr_pkg::CFG_W-1:0]   shadow_taps [3];
  logic [mclfsr_pkg::CFG_W-1:0]   shadow_seed [3];
  bit                             shadow_loaded;

  // Keystream bits still owed by the block, oldest first.
  mclfsr_pkg::res_t pending_bits [$];

  int unsigned err_count;
  int unsigned idle_cycles;
  // When set, both sides run flat out with no gaps and no stalls.
  bit          steady;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------------

  // Mirror one register write; unknown indexes fall through untouched.
  function automatic void shadow_write(logic [mclfsr_pkg::CFG_IDX_W-1:0] idx,
                                       logic [mclfsr_pkg::CFG_W-1:0]     data);
    case (idx)
      mclfsr_pkg::CFG_TAPS_A: shadow_taps[0] = data;
      mclfsr_pkg::CFG_TAPS_B: shadow_taps[1] = data;
      mclfsr_pkg::CFG_TAPS_C: shadow_taps[2] = data;
      mclfsr_pkg::CFG_SEED_A: shadow_seed[0] = data;
      mclfsr_pkg::CFG_SEED_B: shadow_seed[1] = data;
      mclfsr_pkg::CFG_SEED_C: shadow_seed[2] = data;
      default: ;
    endcase
  endfunction

  // Advance all three registers one step and return the bits this request produces.
  function automatic mclfsr_pkg::res_t step_keystream(bit rl);
    mclfsr_pkg::res_t               r;
    logic [mclfsr_pkg::MAX_LEN-1:0] keep;
    logic [2:0]                     top;
    logic                           fb;
    int                             k;
    // Load seeds on the very first step and on every reload, before the outputs form.
    if (!shadow_loaded || rl) begin
      for (k = 0; k < 3; k++) begin
        keep = '1;
        keep = keep >> (mclfsr_pkg::MAX_LEN - SHIFT_LEN[k]);
        shadow_lfsr[k] = shadow_seed[k] & keep;
      end
      shadow_loaded = 1'b1;
    end
    for (k = 0; k < 3; k++) begin
      keep = '1;
      keep = keep >> (mclfsr_pkg::MAX_LEN - SHIFT_LEN[k]);
      top[k] = shadow_lfsr[k][SHIFT_LEN[k]-1];
      fb = ^(shadow_lfsr[k] & shadow_taps[k] & keep);
      shadow_lfsr[k] = ((shadow_lfsr[k] << 1) & keep) |
                       {{(mclfsr_pkg::MAX_LEN-1){1'b0}}, fb};
    end
    r.bit_a   = top[0];
    r.bit_b   = top[1];
    r.bit_c   = top[2];
    r.key_bit = (top[0] & top[1]) | (top[1] & top[2]) | (top[0] & top[2]);
    return r;
  endfunction

  // Favor the all-zero and all-one masks and seeds now and then.
  function automatic logic [mclfsr_pkg::CFG_W-1:0] pick_reg_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return mclfsr_pkg::CFG_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driving side: all inputs change on the falling edge
  // ---------------------------------------------------------------------------

  // Idle a random number of cycles, then present one request and hold it until taken.
  task automatic send_request(bit rl);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    reload   = rl;
    do @(posedge clk); while (in_stall);
    pending_bits.push_back(step_keystream(rl));
  endtask

  // Drop valid and wait for every owed bit, so the block is idle for register writes.
  task automatic drain_requests();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_bits.size() != 0) @(posedge clk);
  endtask

  // One-cycle write pulse; only call with the block drained.
  task automatic write_reg(logic [mclfsr_pkg::CFG_IDX_W-1:0] idx,
                           logic [mclfsr_pkg::CFG_W-1:0]     data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    shadow_write(idx, data);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Stall the result side a random number of cycles before each bit it takes.
  initial begin
    int unsigned hold;
    out_stall = 1'b1;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // ---------------------------------------------------------------------------
  // Checking side: outputs are sampled on the rising edge
  // ---------------------------------------------------------------------------

  task automatic report_field(string name, logic got, logic want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : check_result
    mclfsr_pkg::res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_bits.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual key %0b a %0b b %0b c %0b",
                 $time, key_bit, bit_a, bit_b, bit_c);
        err_count++;
      end else begin
        want = pending_bits.pop_front();
        report_field("key_bit", key_bit, want.key_bit);
        report_field("bit_a",   bit_a,   want.bit_a);
        report_field("bit_b",   bit_b,   want.bit_b);
        report_field("bit_c",   bit_c,   want.bit_c);
      end
    end
  end

  // Count cycles with no traffic of any kind; end the run if the block hangs.
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default taps and seeds: the first request must load the seeds without reload set,
  // and a later reload must restart the sequence.
  task automatic test_power_up();
    repeat (6) send_request(1'b0);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    drain_requests();
  endtask

  // Corner values of every register, deferred seed loads, tap changes mid-stream,
  // ignored high bits and writes to unused indexes.
  task automatic test_register_extremes();
    // Write all ones everywhere; the new seeds must not show until the next reload.
    write_reg(mclfsr_pkg::CFG_TAPS_A, '1);
    write_reg(mclfsr_pkg::CFG_TAPS_B, '1);
    write_reg(mclfsr_pkg::CFG_TAPS_C, '1);
    write_reg(mclfsr_pkg::CFG_SEED_A, '1);
    write_reg(mclfsr_pkg::CFG_SEED_B, '1);
    write_reg(mclfsr_pkg::CFG_SEED_C, '1);
    repeat (2) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    drain_requests();

    // Zero taps: the registers empty out one bit per step after a reload.
    write_reg(mclfsr_pkg::CFG_TAPS_A, '0);
    write_reg(mclfsr_pkg::CFG_TAPS_B, '0);
    write_reg(mclfsr_pkg::CFG_TAPS_C, '0);
    send_request(1'b1);
    send_request(1'b0);
    drain_requests();

    // Seeds with only bits above each length set: every register loads as zero and stays.
    write_reg(mclfsr_pkg::CFG_TAPS_A, '1);
    write_reg(mclfsr_pkg::CFG_TAPS_B, '1);
    write_reg(mclfsr_pkg::CFG_TAPS_C, '1);
    write_reg(mclfsr_pkg::CFG_SEED_A, 15'h7ff0);
    write_reg(mclfsr_pkg::CFG_SEED_B, 15'h7f80);
    write_reg(mclfsr_pkg::CFG_SEED_C, 15'h7e00);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    drain_requests();

    // Writes to unused indexes must change nothing.
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, mclfsr_pkg::CFG_W'($urandom));
    write_reg(mclfsr_pkg::CFG_SEED_A, 15'h0005);
    write_reg(mclfsr_pkg::CFG_SEED_B, 15'h0041);
    write_reg(mclfsr_pkg::CFG_SEED_C, 15'h0101);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    drain_requests();

    // New taps take effect on the very next step, with no reload.
    write_reg(mclfsr_pkg::CFG_TAPS_A, mclfsr_pkg::TAPS_A_RST);
    write_reg(mclfsr_pkg::CFG_TAPS_C, mclfsr_pkg::TAPS_C_RST);
    repeat (3) send_request(1'b0);
    drain_requests();
  endtask

  // Phases of random settings, each followed by a long run of requests with
  // occasional reloads; every third phase runs with no idling on either side.
  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned n;
    int unsigned reload_odds;
    int unsigned idx;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_requests();
      steady = (phase % 3 == 2);
      for (idx = mclfsr_pkg::CFG_TAPS_A; idx <= mclfsr_pkg::CFG_SEED_C; idx++) begin
        if ($urandom_range(0, 2) != 0) begin
          write_reg(mclfsr_pkg::CFG_IDX_W'(idx), pick_reg_value());
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_SPARE_LO + mclfsr_pkg::CFG_IDX_W'($urandom_range(0, 1)),
                  mclfsr_pkg::CFG_W'($urandom));
      end
      reload_odds = $urandom_range(2, 40);
      send_request($urandom_range(0, 1));
      for (n = 1; n < PHASE_REQUESTS; n++) begin
        send_request($urandom_range(1, reload_odds) == 1);
      end
    end
    drain_requests();
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    reload    = 1'b0;
    steady    = 1'b0;
    err_count = 0;

    // Reset state of the shadow: default taps and seeds, empty registers, not loaded.
    shadow_taps   = '{mclfsr_pkg::TAPS_A_RST, mclfsr_pkg::TAPS_B_RST, mclfsr_pkg::TAPS_C_RST};
    shadow_seed   = '{mclfsr_pkg::SEED_RST, mclfsr_pkg::SEED_RST, mclfsr_pkg::SEED_RST};
    shadow_lfsr   = '{'0, '0, '0};
    shadow_loaded = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_power_up();
    test_register_extremes();
    test_random_traffic();

    // Hold off briefly so any stray extra result still shows up as a failure.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* majority_combined_lfsr_bit_generator_top.f */
src/mclfsr_pkg.sv
src/mclfsr_cfg.sv
src/mclfsr_core.sv
src/majority_combined_lfsr_bit_generator_top.sv
tb/sv/tb_top.sv
